[hw/rtl/epws_pkg.sv]
// ----------------------------------------------------------------------------
// epws_pkg
// Shared types, codes and the microcode program of the wheel speed block.
// ----------------------------------------------------------------------------
package epws_pkg;

    localparam int PC_BITS  = 4;
    localparam int DIV_BITS = 32;
    localparam int CNT_BITS = $clog2(DIV_BITS);

    localparam logic [CNT_BITS-1:0] LOOP_LAST = CNT_BITS'(DIV_BITS - 1);

    localparam int CFG_ADDR_BITS = 3;
    localparam int CFG_DATA_BITS = 32;
    localparam int SPEED_BITS    = 11;

    // register indexes
    localparam logic [CFG_ADDR_BITS-1:0] REG_COUNTER_PERIOD  = 3'd0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_WHEEL_PERIMETER = 3'd1;
    localparam logic [CFG_ADDR_BITS-1:0] REG_TICK_RATE       = 3'd2;
    localparam logic [CFG_ADDR_BITS-1:0] REG_SPOKES_PER_TURN = 3'd3;
    localparam logic [CFG_ADDR_BITS-1:0] REG_REDUCTION_RATIO = 3'd4;

    // request kinds
    localparam logic [1:0] REQ_LEFT  = 2'd0;
    localparam logic [1:0] REQ_RIGHT = 2'd1;
    localparam logic [1:0] REQ_TICK  = 2'd2;

    localparam logic [DIV_BITS-1:0] SPEED_LIMIT     = 32'd1000;
    localparam logic [2:0]          WRAP_ZERO_AFTER = 3'd2;
    localparam logic [2:0]          WRAP_MAX        = 3'd5;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_PERIOD,
        OP_NUM_MUL,
        OP_NUM_SCALE,
        OP_DEN_MUL,
        OP_DEN_SCALE,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_COMMIT,
        OP_FINISH,
        OP_TICK
    } op_t;

    typedef enum logic [2:0] {
        C_NEXT,
        C_JUMP,
        C_DISPATCH,
        C_DEN_ZERO,
        C_LOOP
    } cond_t;

    typedef struct packed {
        op_t                op;
        cond_t              cond;
        logic               emit;
        logic [PC_BITS-1:0] target;
    } ctrl_word_t;

    typedef struct packed {
        logic start;
        logic capture;
        logic den_zero;
        logic stall;
    } seq_status_t;

    localparam logic [PC_BITS-1:0] PC_IDLE    = 4'd0;
    localparam logic [PC_BITS-1:0] PC_CAPTURE = 4'd1;
    localparam logic [PC_BITS-1:0] PC_DIV     = 4'd7;
    localparam logic [PC_BITS-1:0] PC_FINISH  = 4'd9;
    localparam logic [PC_BITS-1:0] PC_TICK    = 4'd10;

    function automatic ctrl_word_t ucode(input logic [PC_BITS-1:0] pc);
        ctrl_word_t w;
        w = '{op: OP_NOP, cond: C_JUMP, emit: 1'b0, target: PC_IDLE};
        case (pc)
            4'd0:  w = '{op: OP_NOP,       cond: C_DISPATCH, emit: 1'b0, target: PC_CAPTURE};
            4'd1:  w = '{op: OP_PERIOD,    cond: C_NEXT,     emit: 1'b0, target: PC_IDLE};
            4'd2:  w = '{op: OP_NUM_MUL,   cond: C_NEXT,     emit: 1'b0, target: PC_IDLE};
            4'd3:  w = '{op: OP_NUM_SCALE, cond: C_NEXT,     emit: 1'b0, target: PC_IDLE};
            4'd4:  w = '{op: OP_DEN_MUL,   cond: C_NEXT,     emit: 1'b0, target: PC_IDLE};
            4'd5:  w = '{op: OP_DEN_SCALE, cond: C_NEXT,     emit: 1'b0, target: PC_IDLE};
            4'd6:  w = '{op: OP_DIV_INIT,  cond: C_DEN_ZERO, emit: 1'b0, target: PC_FINISH};
            4'd7:  w = '{op: OP_DIV_STEP,  cond: C_LOOP,     emit: 1'b0, target: PC_DIV};
            4'd8:  w = '{op: OP_COMMIT,    cond: C_NEXT,     emit: 1'b0, target: PC_IDLE};
            4'd9:  w = '{op: OP_FINISH,    cond: C_JUMP,     emit: 1'b1, target: PC_IDLE};
            4'd10: w = '{op: OP_TICK,      cond: C_JUMP,     emit: 1'b1, target: PC_IDLE};
            default: w = '{op: OP_NOP,     cond: C_JUMP,     emit: 1'b0, target: PC_IDLE};
        endcase
        return w;
    endfunction

endpackage

[hw/rtl/encoder_period_wheel_speed.sv]
// ----------------------------------------------------------------------------
// encoder_period_wheel_speed
// Two-wheel speed from encoder capture periods, with a serial divider run by
// a microcoded sequencer.
//
//   channel  direction  contents
//   s_       in         tuser: req_type; tdata: capture_value, direction
//   m_       out        tdata: left_speed, right_speed
//   cfg_     in         register index and write data
//
// a capture runs six setup steps, 32 restoring divide steps, commit and finish
// from acceptance to result; a zero divisor skips the divide and the commit; a
// tick or unused request runs only the tick step
// one transaction at a time; s_tready is high only while the sequencer idles
// a result waits in the output register; the finish or tick step holds while
// it is full and m_tready is low
// aresetn is synchronous, loads the config defaults and clears m_tvalid, speeds, wrap counts and last captures
// ----------------------------------------------------------------------------
module encoder_period_wheel_speed #(
    parameter int CAPTURE_BITS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [CAPTURE_BITS-1:0] capture_value, [CAPTURE_BITS] direction
    input  logic [((CAPTURE_BITS+8)/8)*8-1:0]   s_tdata,
    // [1:0] req_type
    input  logic [1:0]                          s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [10:0] left_speed, [21:11] right_speed
    output logic [23:0]                         m_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [epws_pkg::CFG_ADDR_BITS-1:0]  cfg_addr,
    input  logic [epws_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
    import epws_pkg::*;

    ctrl_word_t  ctrl;
    seq_status_t status;
    logic        idle;
    logic        accept;
    logic        stall;

    logic [16:0] cp_reg,  cp_next;
    logic [15:0] per_reg, per_next;
    logic [26:0] tr_reg,  tr_next;
    logic [7:0]  sp_reg,  sp_next;
    logic [7:0]  rr_reg,  rr_next;

    logic [1:0]              req_reg, req_next;
    logic [CAPTURE_BITS-1:0] cap_reg, cap_next;
    logic                    dir_reg, dir_next;

    logic [CAPTURE_BITS-1:0] left_last_reg,  left_last_next;
    logic [CAPTURE_BITS-1:0] right_last_reg, right_last_next;
    logic [2:0]              left_wraps_reg,  left_wraps_next;
    logic [2:0]              right_wraps_reg, right_wraps_next;
    logic signed [SPEED_BITS-1:0] left_speed_reg,  left_speed_next;
    logic signed [SPEED_BITS-1:0] right_speed_reg, right_speed_next;

    logic [DIV_BITS-1:0] a_reg, a_next;
    logic [DIV_BITS-1:0] b_reg, b_next;
    logic [DIV_BITS-1:0] d_reg, d_next;
    logic [DIV_BITS-1:0] q_reg, q_next;
    logic [DIV_BITS-1:0] r_reg, r_next;

    logic        m_tvalid_reg, m_tvalid_next;
    logic [23:0] m_tdata_reg,  m_tdata_next;

    logic                    is_right;
    logic [2:0]              wraps_sel;
    logic [CAPTURE_BITS-1:0] last_sel;
    logic [19:0]             period_prod;
    logic [42:0]             num_prod;
    logic [15:0]             sd_prod;
    logic [47:0]             den_prod;
    logic [DIV_BITS:0]       rem_shift;
    logic [DIV_BITS:0]       rem_diff;
    logic [2:0]              left_age, right_age;
    logic [SPEED_BITS-1:0]   quot_small;

    assign accept    = s_tvalid && s_tready;
    assign s_tready  = idle;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign stall     = ctrl.emit && m_tvalid_reg && !m_tready;

    assign status.start    = accept;
    assign status.capture  = (s_tuser == REQ_LEFT) || (s_tuser == REQ_RIGHT);
    assign status.den_zero = (d_reg == '0);
    assign status.stall    = stall;

    epws_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (status),
        .ctrl    (ctrl),
        .idle    (idle)
    );

    assign is_right    = (req_reg == REQ_RIGHT);
    assign wraps_sel   = is_right ? right_wraps_reg : left_wraps_reg;
    assign last_sel    = is_right ? right_last_reg : left_last_reg;
    assign period_prod = 20'(wraps_sel) * 20'(cp_reg);
    assign num_prod    = 43'(per_reg) * 43'(tr_reg);
    assign sd_prod     = 16'(sp_reg) * 16'(rr_reg);
    assign den_prod    = 48'(d_reg[15:0]) * 48'(a_reg);
    assign rem_shift   = {r_reg, q_reg[DIV_BITS-1]};
    assign rem_diff    = rem_shift - {1'b0, d_reg};
    assign left_age    = left_wraps_reg + 1'b1;
    assign right_age   = right_wraps_reg + 1'b1;
    assign quot_small  = q_reg[SPEED_BITS-1:0];

    always_comb begin
        cp_next  = cp_reg;
        per_next = per_reg;
        tr_next  = tr_reg;
        sp_next  = sp_reg;
        rr_next  = rr_reg;
        req_next = req_reg;
        cap_next = cap_reg;
        dir_next = dir_reg;
        left_last_next   = left_last_reg;
        right_last_next  = right_last_reg;
        left_wraps_next  = left_wraps_reg;
        right_wraps_next = right_wraps_reg;
        left_speed_next  = left_speed_reg;
        right_speed_next = right_speed_reg;
        a_next = a_reg;
        b_next = b_reg;
        d_next = d_reg;
        q_next = q_reg;
        r_next = r_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;

        if (accept) begin
            req_next = s_tuser;
            cap_next = s_tdata[CAPTURE_BITS-1:0];
            dir_next = s_tdata[CAPTURE_BITS];
        end

        if (!stall) begin
            case (ctrl.op)
                OP_PERIOD:    a_next = 32'(period_prod) + 32'(cap_reg) - 32'(last_sel);
                OP_NUM_MUL:   b_next = num_prod[DIV_BITS-1:0];
                OP_NUM_SCALE: b_next = (b_reg << 3) + (b_reg << 1);
                OP_DEN_MUL:   d_next = 32'(sd_prod);
                OP_DEN_SCALE: d_next = den_prod[DIV_BITS-1:0];
                OP_DIV_INIT: begin
                    r_next = '0;
                    q_next = b_reg;
                end
                OP_DIV_STEP: begin
                    if (!rem_diff[DIV_BITS]) begin
                        r_next = rem_diff[DIV_BITS-1:0];
                    end else begin
                        r_next = rem_shift[DIV_BITS-1:0];
                    end
                    q_next = {q_reg[DIV_BITS-2:0], !rem_diff[DIV_BITS]};
                end
                OP_COMMIT: begin
                    if (q_reg <= SPEED_LIMIT) begin
                        if (is_right) begin
                            right_speed_next = dir_reg ? quot_small : -quot_small;
                        end else begin
                            left_speed_next = dir_reg ? quot_small : -quot_small;
                        end
                    end
                end
                OP_FINISH: begin
                    if (is_right) begin
                        right_last_next  = cap_reg;
                        right_wraps_next = '0;
                    end else begin
                        left_last_next  = cap_reg;
                        left_wraps_next = '0;
                    end
                end
                OP_TICK: begin
                    if (req_reg == REQ_TICK) begin
                        left_wraps_next  = (left_age > WRAP_MAX) ? WRAP_MAX : left_age;
                        right_wraps_next = (right_age > WRAP_MAX) ? WRAP_MAX : right_age;
                        if (left_age > WRAP_ZERO_AFTER) begin
                            left_speed_next = '0;
                        end
                        if (right_age > WRAP_ZERO_AFTER) begin
                            right_speed_next = '0;
                        end
                    end
                end
                default: begin
                end
            endcase
            if (ctrl.emit) begin
                m_tvalid_next = 1'b1;
                m_tdata_next  = {2'b00, right_speed_next, left_speed_next};
            end
        end

        if (cfg_valid && cfg_ready) begin
            case (cfg_addr)
                REG_COUNTER_PERIOD:  cp_next  = cfg_data[16:0];
                REG_WHEEL_PERIMETER: per_next = cfg_data[15:0];
                REG_TICK_RATE:       tr_next  = cfg_data[26:0];
                REG_SPOKES_PER_TURN: sp_next  = cfg_data[7:0];
                REG_REDUCTION_RATIO: rr_next  = cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cp_reg  <= 17'd65536;
            per_reg <= 16'd200;
            tr_reg  <= 27'd720000;
            sp_reg  <= 8'd20;
            rr_reg  <= 8'd30;
            left_last_reg   <= '0;
            right_last_reg  <= '0;
            left_wraps_reg  <= '0;
            right_wraps_reg <= '0;
            left_speed_reg  <= '0;
            right_speed_reg <= '0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            cp_reg  <= cp_next;
            per_reg <= per_next;
            tr_reg  <= tr_next;
            sp_reg  <= sp_next;
            rr_reg  <= rr_next;
            left_last_reg   <= left_last_next;
            right_last_reg  <= right_last_next;
            left_wraps_reg  <= left_wraps_next;
            right_wraps_reg <= right_wraps_next;
            left_speed_reg  <= left_speed_next;
            right_speed_reg <= right_speed_next;
            m_tvalid_reg    <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg <= req_next;
        cap_reg <= cap_next;
        dir_reg <= dir_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        d_reg   <= d_next;
        q_reg   <= q_next;
        r_reg   <= r_next;
        m_tdata_reg <= m_tdata_next;
    end

endmodule

[hw/rtl/epws_seq.sv]
// ----------------------------------------------------------------------------
// epws_seq
// Step counter, loop counter and microcode table; issues one control word
// per cycle to the datapath.
// ----------------------------------------------------------------------------
module epws_seq (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  epws_pkg::seq_status_t status,
    output epws_pkg::ctrl_word_t  ctrl,
    output logic                 idle
);
    import epws_pkg::*;

    logic [PC_BITS-1:0]  pc_reg, pc_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;

    assign ctrl = ucode(pc_reg);
    assign idle = (pc_reg == PC_IDLE);

    always_comb begin
        pc_next  = pc_reg + 1'b1;
        cnt_next = '0;
        case (ctrl.cond)
            C_NEXT:     pc_next = pc_reg + 1'b1;
            C_JUMP:     pc_next = ctrl.target;
            C_DISPATCH: begin
                if (!status.start) begin
                    pc_next = pc_reg;
                end else if (status.capture) begin
                    pc_next = ctrl.target;
                end else begin
                    pc_next = PC_TICK;
                end
            end
            C_DEN_ZERO: pc_next = status.den_zero ? ctrl.target : pc_reg + 1'b1;
            C_LOOP: begin
                if (cnt_reg != LOOP_LAST) begin
                    pc_next  = ctrl.target;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            default:    pc_next = PC_IDLE;
        endcase
        if (ctrl.emit && status.stall) begin
            pc_next  = pc_reg;
            cnt_next = cnt_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg  <= PC_IDLE;
            cnt_reg <= '0;
        end else begin
            pc_reg  <= pc_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

[hw/rtl/epws_checker.sv]
// ----------------------------------------------------------------------------
// epws_checker
// Port-level checks for the wheel speed block, bound to the top level.
// ----------------------------------------------------------------------------
module epws_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_tvalid,
    input logic                                s_tready,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [23:0]                         m_tdata
);
    import epws_pkg::*;

    // result held while stalled
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // speeds stay within the limit
    a_speed_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata[10:0]) <= 11'sd1000)
            && ($signed(m_tdata[10:0]) >= -11'sd1000)
            && ($signed(m_tdata[21:11]) <= 11'sd1000)
            && ($signed(m_tdata[21:11]) >= -11'sd1000)
            && (m_tdata[23:22] == 2'b00))
        else $error("speed out of range");

    // one transaction in flight at a time
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while busy");

    // no result right after reset
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind encoder_period_wheel_speed epws_checker u_epws_checker (.*);
